// ===== hdl/top_k_sorted_score_table_defines.svh =====
// assertion macros used by the score table rtl
`ifndef TOP_K_SORTED_SCORE_TABLE_DEFINES_SVH
`define TOP_K_SORTED_SCORE_TABLE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TKST_ASSERT_HOLDS(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define TKST_ASSERT_NEXT(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/tkst_pkg.sv =====
// types and constants of the sorted score table
package tkst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int MOVES_W = 16;
  localparam int MIN_W = 16;
  localparam int SEC_W = 6;
  localparam int TAG_W = 16;
  localparam int RIDX_W = 4;
  localparam int POS_W = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_PROBE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [MOVES_W-1:0] moves;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    cmd_t              cmd;
    entry_t            ent;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic accepted;
    logic [POS_W-1:0] position;
    logic entry_valid;
    entry_t ent;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

endpackage

// ===== hdl/tkst_store.sv =====
// entry memory: one write port, one registered read port
module tkst_store (
  input  logic             clk,
  input  tkst_pkg::mem_wr_t wr,
  input  tkst_pkg::mem_rd_t rd,
  output tkst_pkg::entry_t  rd_data
);
  import tkst_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== hdl/tkst_cmp.sv =====
// lexicographic key compare: new key strictly ahead of a stored entry
module tkst_cmp (
  input  tkst_pkg::entry_t key,
  input  tkst_pkg::entry_t stored,
  output logic             beats
);
  import tkst_pkg::*;

  always_comb begin
    if (key.moves != stored.moves) begin
      beats = key.moves < stored.moves;
    end else if (key.minutes != stored.minutes) begin
      beats = key.minutes < stored.minutes;
    end else begin
      beats = key.seconds < stored.seconds;
    end
  end

endmodule

// ===== hdl/tkst_ctrl.sv =====
// sequencer: scan, shift, write and read steps over the entry memory
`include "top_k_sorted_score_table_defines.svh"

module tkst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tkst_pkg::req_t    req,
  output tkst_pkg::mem_wr_t mem_wr,
  output tkst_pkg::mem_rd_t mem_rd,
  input  tkst_pkg::entry_t  rd_data,
  output tkst_pkg::entry_t  cmp_key,
  input  logic              beats,
  output logic              res_valid,
  input  logic              res_ready,
  output tkst_pkg::res_t    res
);
  import tkst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_READ_RD,
    S_READ_WAIT,
    S_RESP
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] pos;
  logic             acc;
  logic             ent_valid;
  entry_t           rent;

  logic             not_full;
  logic [CNT_W-1:0] last;
  logic             read_hit;

  assign not_full = count < CNT_W'(TABLE_DEPTH);
  assign last     = not_full ? count : CNT_W'(TABLE_DEPTH - 1);
  assign read_hit = cur.read_index < count;

  assign req_stall = state != S_IDLE;
  assign cmp_key   = cur.ent;
  assign res_valid = state == S_RESP;

  always_comb begin
    res.accepted    = acc;
    res.position    = POS_W'(pos);
    res.entry_valid = ent_valid;
    res.ent         = rent;
    res.count       = CNT_OUT_W'(count);
  end

  always_comb begin
    mem_rd = '0;
    mem_wr = '0;
    case (state)
      S_SCAN_RD: begin
        mem_rd.en   = idx != count;
        mem_rd.addr = IDX_W'(idx);
      end
      S_SHIFT_RD: begin
        mem_rd.en   = idx > CNT_W'(pos);
        mem_rd.addr = IDX_W'(idx - 1'b1);
      end
      S_SHIFT_WR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = IDX_W'(idx);
        mem_wr.data = rd_data;
      end
      S_PUT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = pos;
        mem_wr.data = cur.ent;
      end
      S_READ_RD: begin
        mem_rd.en   = read_hit;
        mem_rd.addr = IDX_W'(cur.read_index);
      end
      default: begin
        mem_rd = '0;
        mem_wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur       <= req;
            idx       <= '0;
            pos       <= '0;
            acc       <= 1'b0;
            ent_valid <= 1'b0;
            rent      <= '0;
            case (req.cmd)
              CMD_INSERT, CMD_PROBE: state <= S_SCAN_RD;
              CMD_READ:              state <= S_READ_RD;
              CMD_CLEAR: begin
                count <= '0;
                state <= S_RESP;
              end
              default:               state <= S_RESP;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            // beats no stored entry: append if there is room
            if (not_full) begin
              pos   <= IDX_W'(count);
              acc   <= 1'b1;
              idx   <= last;
              state <= (cur.cmd == CMD_INSERT) ? S_SHIFT_RD : S_RESP;
            end else begin
              state <= S_RESP;
            end
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (beats) begin
            pos   <= IDX_W'(idx);
            acc   <= 1'b1;
            idx   <= last;
            state <= (cur.cmd == CMD_INSERT) ? S_SHIFT_RD : S_RESP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= (idx > CNT_W'(pos)) ? S_SHIFT_WR : S_PUT;
        end
        S_SHIFT_WR: begin
          idx   <= idx - 1'b1;
          state <= S_SHIFT_RD;
        end
        S_PUT: begin
          if (not_full) begin
            count <= count + 1'b1;
          end
          state <= S_RESP;
        end
        S_READ_RD: begin
          state <= read_hit ? S_READ_WAIT : S_RESP;
        end
        S_READ_WAIT: begin
          ent_valid <= 1'b1;
          rent      <= rd_data;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TKST_ASSERT_HOLDS(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH), "count above depth")
  `TKST_ASSERT_NEXT(a_req_starts, clk, rst, state == S_IDLE && req_valid, state != S_IDLE, "request not taken")
  `TKST_ASSERT_HOLDS(a_shift_above_slot, clk, rst, state == S_SHIFT_WR, idx > CNT_W'(pos), "shift below slot")
  `TKST_ASSERT_NEXT(a_put_grows, clk, rst, state == S_PUT && not_full, count == $past(count) + 1'b1, "count not bumped")

endmodule

// ===== hdl/top_k_sorted_score_table.sv =====
// channel  | signals                                          | direction
// request  | in_valid, in_stall, cmd, moves, minutes, seconds, | in (stall out)
//          | player_tag, read_index                           |
// result   | out_valid, out_stall, accepted, position,        | out (stall in)
//          | entry_valid, out_moves, out_minutes, out_seconds, |
//          | out_tag, count                                   |
//
// insert/probe: a read step and a compare step per stored entry compared, until
// the first one beaten, then for an insert a read step and a write step per entry
// moved down, one read step to close the shift and one for the write of the new
// entry.
// read has a read step and, on a hit, a wait step; clear goes straight to the
// result; one request is in work at a time. reset empties the table at once; no
// clearing pass over the memory. a finished result sits in the output register,
// so the next request is taken while out_stall holds it.
module top_k_sorted_score_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tkst_pkg::CMD_W-1:0]     cmd,
  input  logic [tkst_pkg::MOVES_W-1:0]   moves,
  input  logic [tkst_pkg::MIN_W-1:0]     minutes,
  input  logic [tkst_pkg::SEC_W-1:0]     seconds,
  input  logic [tkst_pkg::TAG_W-1:0]     player_tag,
  input  logic [tkst_pkg::RIDX_W-1:0]    read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [tkst_pkg::POS_W-1:0]     position,
  output logic                          entry_valid,
  output logic [tkst_pkg::MOVES_W-1:0]   out_moves,
  output logic [tkst_pkg::MIN_W-1:0]     out_minutes,
  output logic [tkst_pkg::SEC_W-1:0]     out_seconds,
  output logic [tkst_pkg::TAG_W-1:0]     out_tag,
  output logic [tkst_pkg::CNT_OUT_W-1:0] count
);
  import tkst_pkg::*;

  req_t    req;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  entry_t  rd_data;
  entry_t  cmp_key;
  logic    beats;
  logic    res_valid;
  logic    res_ready;
  res_t    res;
  res_t    out_q;

  always_comb begin
    req.cmd         = cmd_t'(cmd);
    req.ent.moves   = moves;
    req.ent.minutes = minutes;
    req.ent.seconds = seconds;
    req.ent.tag     = player_tag;
    req.read_index  = read_index;
  end

  tkst_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  tkst_cmp u_cmp (
    .key    (cmp_key),
    .stored (rd_data),
    .beats  (beats)
  );

  tkst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (req),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .rd_data   (rd_data),
    .cmp_key   (cmp_key),
    .beats     (beats),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees up in the cycle its result is taken
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign accepted    = out_q.accepted;
  assign position    = out_q.position;
  assign entry_valid = out_q.entry_valid;
  assign out_moves   = out_q.ent.moves;
  assign out_minutes = out_q.ent.minutes;
  assign out_seconds = out_q.ent.seconds;
  assign out_tag     = out_q.ent.tag;
  assign count       = out_q.count;

endmodule

// ===== tb/top_k_sorted_score_table_test.sv =====
// testbench for the sorted score table: directed request table, then random requests
module top_k_sorted_score_table_test;
  import tkst_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 750;
  localparam int HOLD_CYCLES    = 600;
  localparam int ROWS           = 25;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd = CMD_INSERT;
  logic [MOVES_W-1:0]   moves = '0;
  logic [MIN_W-1:0]     minutes = '0;
  logic [SEC_W-1:0]     seconds = '0;
  logic [TAG_W-1:0]     player_tag = '0;
  logic [RIDX_W-1:0]    read_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 accepted;
  logic [POS_W-1:0]     position;
  logic                 entry_valid;
  logic [MOVES_W-1:0]   out_moves;
  logic [MIN_W-1:0]     out_minutes;
  logic [SEC_W-1:0]     out_seconds;
  logic [TAG_W-1:0]     out_tag;
  logic [CNT_OUT_W-1:0] count;

  // one directed request; pin marks rows whose result is typed in here
  // for a pinned read the key and tag columns hold the entry expected back
  typedef struct packed {
    cmd_t                 cmd;
    logic [MOVES_W-1:0]   moves;
    logic [MIN_W-1:0]     minutes;
    logic [SEC_W-1:0]     seconds;
    logic [TAG_W-1:0]     tag;
    logic [RIDX_W-1:0]    ridx;
    logic [4:0]           reps;
    logic                 pin;
    logic                 acc;
    logic [POS_W-1:0]     pos;
    logic                 ev;
    logic [CNT_OUT_W-1:0] cnt;
  } score_row_t;

  score_row_t directed_rows [ROWS] = '{
    // empty table after reset
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd15, 5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_PROBE,  16'hFFFF, 16'hFFFF, 6'd59, 16'hFFFF, 4'd0,  5'd1,  1'b1, 1'b1, 4'd0, 1'b0, 5'd0},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 6'd59, 16'hFFFF, 4'd0,  5'd1,  1'b1, 1'b1, 4'd0, 1'b0, 5'd1},
    '{CMD_INSERT, 16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b1, 4'd0, 1'b0, 5'd2},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b1, 5'd2},
    '{CMD_READ,   16'hFFFF, 16'hFFFF, 6'd59, 16'hFFFF, 4'd1,  5'd1,  1'b1, 1'b0, 4'd0, 1'b1, 5'd2},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd2,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd2},
    // equal keys do not beat; minutes and seconds break ties
    '{CMD_INSERT, 16'h0000, 16'h0000, 6'd0,  16'h1234, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFE, 6'd59, 16'h5555, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 6'd58, 16'hAAAA, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 6'd59, 16'h00FF, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_PROBE,  16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd1,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_CLEAR,  16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
    // fill to the top, each one appended
    '{CMD_INSERT, 16'd100,  16'd7,    6'd30, 16'h0100, 4'd0,  5'd16, 1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    // full table, new key beats nothing
    '{CMD_PROBE,  16'hFFFF, 16'hFFFF, 6'd59, 16'hFFFF, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd16},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 6'd59, 16'hFFFF, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd16},
    // full table, last entry drops out
    '{CMD_INSERT, 16'd100,  16'd7,    6'd30, 16'h0200, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_INSERT, 16'h0000, 16'h0000, 6'd0,  16'hBEEF, 4'd0,  5'd1,  1'b1, 1'b1, 4'd0, 1'b0, 5'd16},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd15, 5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_READ,   16'h0000, 16'h0000, 6'd0,  16'hBEEF, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b1, 5'd16},
    '{CMD_PROBE,  16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
    '{CMD_CLEAR,  16'h0000, 16'h0000, 6'd0,  16'h0000, 4'd0,  5'd1,  1'b1, 1'b0, 4'd0, 1'b0, 5'd0}
  };

  // predictor state: ranked entries and how many are valid
  entry_t      score_rank [TABLE_DEPTH];
  int unsigned score_count = 0;

  res_t        expected_results [$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  int unsigned turned_away = 0;
  int unsigned idle_cycles = 0;
  int          burst_left = 0;

  top_k_sorted_score_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .moves      (moves),
    .minutes    (minutes),
    .seconds    (seconds),
    .player_tag (player_tag),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .position   (position),
    .entry_valid(entry_valid),
    .out_moves  (out_moves),
    .out_minutes(out_minutes),
    .out_seconds(out_seconds),
    .out_tag    (out_tag),
    .count      (count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit key_beats(entry_t cand, entry_t held);
    if (cand.moves != held.moves) return cand.moves < held.moves;
    if (cand.minutes != held.minutes) return cand.minutes < held.minutes;
    return cand.seconds < held.seconds;
  endfunction

  task automatic predict_score(input req_t rq, output res_t rs);
    int unsigned slot;
    int unsigned last;
    bit          found;
    bit          fits;
    int          k;
    rs = '0;
    case (rq.cmd)
      CMD_INSERT, CMD_PROBE: begin
        slot = score_count;
        found = 1'b0;
        for (k = 0; k < score_count; k++) begin
          if (!found && key_beats(rq.ent, score_rank[k])) begin
            slot = k;
            found = 1'b1;
          end
        end
        fits = found || (score_count < TABLE_DEPTH);
        if (fits && rq.cmd == CMD_INSERT) begin
          // shift down from the slot; the last entry falls off when full
          last = (score_count < TABLE_DEPTH) ? score_count : TABLE_DEPTH - 1;
          for (k = last; k > slot; k--) score_rank[k] = score_rank[k-1];
          score_rank[slot] = rq.ent;
          if (score_count < TABLE_DEPTH) score_count++;
        end
        rs.accepted = fits;
        rs.position = fits ? POS_W'(slot) : '0;
      end
      CMD_READ: begin
        if (rq.read_index < score_count) begin
          rs.entry_valid = 1'b1;
          rs.ent = score_rank[rq.read_index];
        end
      end
      default: score_count = 0;
    endcase
    rs.count = CNT_OUT_W'(score_count);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // offer one request and hold it until taken, then log its expected result
  task automatic send_request(input req_t rq, input bit pinned, input res_t pinned_res);
    res_t predicted;
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= rq.cmd;
    moves      <= rq.ent.moves;
    minutes    <= rq.ent.minutes;
    seconds    <= rq.ent.seconds;
    player_tag <= rq.ent.tag;
    read_index <= rq.read_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_score(rq, predicted);
    expected_results = {expected_results, (pinned ? pinned_res : predicted)};
    cmd_seen[rq.cmd]++;
    if ((rq.cmd == CMD_INSERT || rq.cmd == CMD_PROBE) && !predicted.accepted) turned_away++;
  endtask

  // requests go out in bursts; a gap drops valid for a random number of cycles
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 30);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // small values most of the time so that keys tie often
  function automatic logic [15:0] pick_key16();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin : stimulus
    req_t rq;
    res_t pinned_res;
    int   k;
    int   n;
    int   pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        rq.cmd         = directed_rows[i].cmd;
        rq.ent.moves   = directed_rows[i].moves + 16'(k);
        rq.ent.minutes = directed_rows[i].minutes;
        rq.ent.seconds = directed_rows[i].seconds;
        rq.ent.tag     = directed_rows[i].tag + 16'(k);
        rq.read_index  = directed_rows[i].ridx;
        pinned_res = '0;
        pinned_res.accepted    = directed_rows[i].acc;
        pinned_res.position    = directed_rows[i].pos;
        pinned_res.entry_valid = directed_rows[i].ev;
        pinned_res.count       = directed_rows[i].cnt;
        if (directed_rows[i].cmd == CMD_READ) pinned_res.ent = rq.ent;
        send_request(rq, directed_rows[i].pin, pinned_res);
        pace_sender();
      end
    end

    pinned_res = '0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      rq.cmd = CMD_INSERT;
      else if (pick < 65) rq.cmd = CMD_PROBE;
      else if (pick < 97) rq.cmd = CMD_READ;
      else                rq.cmd = CMD_CLEAR;
      rq.ent.moves   = pick_key16();
      rq.ent.minutes = pick_key16();
      case ($urandom_range(0, 5))
        0:       rq.ent.seconds = 6'd0;
        1:       rq.ent.seconds = 6'd59;
        2, 3:    rq.ent.seconds = 6'($urandom_range(0, 3));
        default: rq.ent.seconds = 6'($urandom_range(0, 59));
      endcase
      rq.ent.tag    = 16'($urandom);
      rq.read_index = 4'($urandom_range(0, 15));
      send_request(rq, 1'b0, pinned_res);
      pace_sender();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("covered %0d requests: %0d insert, %0d probe, %0d read, %0d clear",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[CMD_INSERT], cmd_seen[CMD_PROBE], cmd_seen[CMD_READ],
             cmd_seen[CMD_CLEAR]);
    $display("%0d results compared, %0d inserts or probes turned away by a full table",
             results_checked, turned_away);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: stall patterns that change every so often, one long hold-off
  initial begin : receiver
    int seg;
    int len;
    int mode;
    int k;
    seg = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (seg == 4) begin
        // hold results back long enough for the block to stall its input
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(20, 150);
        for (k = 0; k < len; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 0);
            2:       out_stall <= ($urandom_range(0, 9) != 0);
            default: out_stall <= ((k % 5) < 2);
          endcase
        end
      end
      seg++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_result
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = expected_results.pop_front();
        compare_field("accepted", accepted, want.accepted);
        compare_field("position", position, want.position);
        compare_field("entry_valid", entry_valid, want.entry_valid);
        compare_field("out_moves", out_moves, want.ent.moves);
        compare_field("out_minutes", out_minutes, want.ent.minutes);
        compare_field("out_seconds", out_seconds, want.ent.seconds);
        compare_field("out_tag", out_tag, want.ent.tag);
        compare_field("count", count, want.count);
      end
      results_checked++;
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

endmodule
